>>> rtl/jdce_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the JPEG DCT coefficient effect block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package jdce_pkg;

    localparam int COEF_W      = 12;
    localparam int QUANT_W     = 16;
    localparam int OFFSET_W    = 13;
    localparam int MODE_W      = 3;
    localparam int COMP_W      = 2;
    localparam int POS_W       = 6;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = 16;
    localparam int PROD_W      = COEF_W + QUANT_W + 1;
    localparam int SUM_W       = PROD_W + 1;
    localparam int MAG_W       = COEF_W - 1;
    localparam int DIV_STEPS   = MAG_W;
    localparam int CNT_W       = 4;
    localparam int REM_W       = QUANT_W + 1;
    localparam int DC_LIMIT    = 2047;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 16;

    localparam logic [COMP_W-1:0] COMP_Y  = 2'd0;
    localparam logic [COMP_W-1:0] COMP_CB = 2'd1;
    localparam logic [COMP_W-1:0] COMP_CR = 2'd2;
    localparam logic [POS_W-1:0]  POS_DC  = 6'd0;

    typedef enum logic [MODE_W-1:0] {
        MODE_PASS  = 3'd0,
        MODE_GRAY  = 3'd1,
        MODE_PIXEL = 3'd2,
        MODE_TINT  = 3'd3,
        MODE_LUMA  = 3'd4
    } t_mode;

    typedef enum logic [CFG_AW-1:0] {
        CFG_MODE     = 3'd0,
        CFG_YCBCR    = 3'd1,
        CFG_LUMA_OFF = 3'd2,
        CFG_CB_OFF   = 3'd3,
        CFG_CR_OFF   = 3'd4,
        CFG_QUANT_Y  = 3'd5,
        CFG_QUANT_CB = 3'd6,
        CFG_QUANT_CR = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_CLAMP,
        BK_DIV,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic                       is_div;
        logic [COEF_W-1:0]          coef;
        logic                       status;
        logic                       last;
        logic [QUANT_W-1:0]         quant;
        logic signed [OFFSET_W-1:0] offset;
    } t_entry;

    typedef struct packed {
        logic   valid;
        logic   full;
        t_entry head;
    } t_queue_stat;

endpackage

>>> rtl/jdce_front.sv
`timescale 1ns / 1ps
// Front end: holds the configuration registers and classifies each input item.
// Depends on jdce_pkg.
module jdce_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [jdce_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [jdce_pkg::CFG_DW-1:0]     i_cfg_wdata,
    input  logic [jdce_pkg::COMP_W-1:0]     i_component,
    input  logic [jdce_pkg::POS_W-1:0]      i_position,
    input  logic [jdce_pkg::COEF_W-1:0]     i_coef,
    input  logic                            i_last,
    output jdce_pkg::t_entry                o_entry
);
    import jdce_pkg::*;

    logic [MODE_W-1:0]          r_mode;
    logic                       r_ycbcr;
    logic signed [OFFSET_W-1:0] r_luma_off;
    logic signed [OFFSET_W-1:0] r_cb_off;
    logic signed [OFFSET_W-1:0] r_cr_off;
    logic [QUANT_W-1:0]         r_quant_y;
    logic [QUANT_W-1:0]         r_quant_cb;
    logic [QUANT_W-1:0]         r_quant_cr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_PASS;
            r_ycbcr    <= 1'b1;
            r_luma_off <= '0;
            r_cb_off   <= '0;
            r_cr_off   <= '0;
            r_quant_y  <= QUANT_W'(1);
            r_quant_cb <= QUANT_W'(1);
            r_quant_cr <= QUANT_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_MODE:     r_mode     <= i_cfg_wdata[MODE_W-1:0];
                CFG_YCBCR:    r_ycbcr    <= i_cfg_wdata[0];
                CFG_LUMA_OFF: r_luma_off <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_CB_OFF:   r_cb_off   <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_CR_OFF:   r_cr_off   <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_QUANT_Y:  r_quant_y  <= i_cfg_wdata[QUANT_W-1:0];
                CFG_QUANT_CB: r_quant_cb <= i_cfg_wdata[QUANT_W-1:0];
                CFG_QUANT_CR: r_quant_cr <= i_cfg_wdata[QUANT_W-1:0];
            endcase
        end
    end

    // A quantizer register holding zero acts as one.
    function automatic logic [QUANT_W-1:0] fix_q(input logic [QUANT_W-1:0] q);
        return (q == '0) ? QUANT_W'(1) : q;
    endfunction

    always_comb begin
        o_entry        = '0;
        o_entry.coef   = i_coef;
        o_entry.last   = i_last;
        o_entry.quant  = fix_q(r_quant_y);
        o_entry.offset = r_luma_off;
        unique case (t_mode'(r_mode))
            MODE_GRAY: begin
                if (i_component != COMP_Y) o_entry.coef = '0;
            end
            MODE_PIXEL: begin
                if (i_position != POS_DC) o_entry.coef = '0;
            end
            MODE_TINT: begin
                if (!r_ycbcr) begin
                    o_entry.status = 1'b1;
                end else if (i_position == POS_DC) begin
                    if (i_component == COMP_CB && r_cb_off != '0) begin
                        o_entry.is_div = 1'b1;
                        o_entry.quant  = fix_q(r_quant_cb);
                        o_entry.offset = r_cb_off;
                    end else if (i_component == COMP_CR && r_cr_off != '0) begin
                        o_entry.is_div = 1'b1;
                        o_entry.quant  = fix_q(r_quant_cr);
                        o_entry.offset = r_cr_off;
                    end
                end
            end
            MODE_LUMA: begin
                if (i_component == COMP_Y && i_position == POS_DC) o_entry.is_div = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/jdce_queue.sv
`timescale 1ns / 1ps
// Short queue of classified items between the front and back ends.
// Depends on jdce_pkg.
module jdce_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  jdce_pkg::t_entry      i_entry,
    input  logic                  i_pop,
    output jdce_pkg::t_queue_stat o_stat
);
    import jdce_pkg::*;

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr;
    logic [QUEUE_AW-1:0]   r_rd;
    logic [QUEUE_AW:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end

    always_comb begin
        o_stat.valid = (r_count != '0);
        o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
        o_stat.head  = r_mem[r_rd];
    end

endmodule

>>> rtl/jdce_back.sv
`timescale 1ns / 1ps
// Back end: passes finished items to the output register and runs the DC
// shift (multiply, clamp, restoring divide). Depends on jdce_pkg.
module jdce_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  jdce_pkg::t_queue_stat       i_stat,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [jdce_pkg::COEF_W-1:0] o_coef,
    output logic                        o_status,
    output logic                        o_last
);
    import jdce_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(DC_LIMIT);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX;

    t_back_state                r_state;
    t_back_state                n_state;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [OFFSET_W-1:0] r_off;
    logic [QUANT_W-1:0]         r_q;
    logic                       r_last;
    logic                       r_neg;
    logic [MAG_W-1:0]           r_quo;
    logic [REM_W-1:0]           r_rem;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_valid;
    logic [COEF_W-1:0]          r_coef;
    logic                       r_status;
    logic                       r_olast;

    logic                       w_out_free;
    logic                       w_load;
    logic [COEF_W-1:0]          w_coef;
    logic                       w_status;
    logic                       w_last;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [COEF_W-1:0]   w_clamp;
    logic [REM_W-1:0]           w_trial;
    logic                       w_fit;

    assign w_out_free = !r_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_RUN: begin
                if (i_stat.valid && i_stat.head.is_div) n_state = BK_CLAMP;
            end
            BK_CLAMP: n_state = BK_DIV;
            BK_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = BK_DONE;
            end
            BK_DONE: begin
                if (w_out_free) n_state = BK_RUN;
            end
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        w_load   = 1'b0;
        w_coef   = i_stat.head.coef;
        w_status = i_stat.head.status;
        w_last   = i_stat.head.last;
        unique case (r_state)
            BK_RUN: begin
                o_pop  = i_stat.valid && (i_stat.head.is_div || w_out_free);
                w_load = i_stat.valid && !i_stat.head.is_div && w_out_free;
            end
            BK_DONE: begin
                w_load   = w_out_free;
                w_coef   = r_neg ? COEF_W'(-$signed({1'b0, r_quo})) : {1'b0, r_quo};
                w_status = 1'b0;
                w_last   = r_last;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_sum = SUM_W'(r_prod) + SUM_W'(r_off);
        if (w_sum > SUM_MAX) begin
            w_clamp = COEF_W'(SUM_MAX);
        end else if (w_sum < SUM_MIN) begin
            w_clamp = COEF_W'(SUM_MIN);
        end else begin
            w_clamp = w_sum[COEF_W-1:0];
        end
    end

    assign w_trial = {r_rem[REM_W-2:0], r_quo[MAG_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_RUN;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load)        r_valid <= 1'b1;
            else if (i_ready)  r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_coef   <= w_coef;
            r_status <= w_status;
            r_olast  <= w_last;
        end
        unique case (r_state)
            BK_RUN: begin
                r_prod <= PROD_W'($signed(i_stat.head.coef))
                        * PROD_W'($signed({1'b0, i_stat.head.quant}));
                r_off  <= i_stat.head.offset;
                r_q    <= i_stat.head.quant;
                r_last <= i_stat.head.last;
            end
            BK_CLAMP: begin
                r_neg <= w_clamp[COEF_W-1];
                r_quo <= w_clamp[COEF_W-1] ? MAG_W'(-w_clamp) : w_clamp[MAG_W-1:0];
                r_rem <= '0;
                r_cnt <= '0;
            end
            BK_DIV: begin
                r_rem <= w_fit ? (w_trial - {1'b0, r_q}) : w_trial;
                r_quo <= {r_quo[MAG_W-2:0], w_fit};
                r_cnt <= r_cnt + 1'b1;
            end
            BK_DONE: begin
            end
        endcase
    end

    assign o_valid  = r_valid;
    assign o_coef   = r_coef;
    assign o_status = r_status;
    assign o_last   = r_olast;

endmodule

>>> rtl/jpeg_dct_coefficient_effect_core.sv
`timescale 1ns / 1ps
// Top level of the JPEG DCT coefficient effect block: front, queue and back.
// Depends on jdce_pkg, jdce_front, jdce_queue and jdce_back.
//
//  channel   direction  tdata                          tuser       tlast
//  s_axis    in         [5:0] position, [17:6] coef_in component   last_in
//  m_axis    out        [11:0] coef_out                status      last_out
//  cfg       in         i_cfg_addr selects the register, i_cfg_wdata the value
//
// Items that need no DC shift pass from the queue head into the output register,
// one item per cycle while the output is not stalled. A shifted DC item holds the
// back end for one multiply, one clamp, 11 restoring divider steps and the output.
// The four-entry queue absorbs up to four items while the divider works; once
// it is full, s_axis_tready drops until the back end takes the next item.
// Reset is synchronous and empties the queue and the output register.
module jpeg_dct_coefficient_effect_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [jdce_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  logic [jdce_pkg::CFG_DW-1:0]       i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [jdce_pkg::S_DATA_W-1:0]     s_axis_tdata,  // position, coef_in
    input  logic [jdce_pkg::COMP_W-1:0]       s_axis_tuser,  // component
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [jdce_pkg::M_DATA_W-1:0]     m_axis_tdata,  // coef_out
    output logic                              m_axis_tuser,  // status
    output logic                              m_axis_tlast
);
    import jdce_pkg::*;

    t_entry            w_entry;
    t_queue_stat       w_stat;
    logic              w_pop;
    logic              w_push;
    logic [COEF_W-1:0] w_coef;

    assign s_axis_tready = !w_stat.full;
    assign w_push        = s_axis_tvalid && !w_stat.full;

    jdce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_component (s_axis_tuser),
        .i_position  (s_axis_tdata[POS_W-1:0]),
        .i_coef      (s_axis_tdata[POS_W+COEF_W-1:POS_W]),
        .i_last      (s_axis_tlast),
        .o_entry     (w_entry)
    );

    jdce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_stat  (w_stat)
    );

    jdce_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stat   (w_stat),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_coef   (w_coef),
        .o_status (m_axis_tuser),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {(M_DATA_W-COEF_W)'(0), w_coef};

endmodule

>>> rtl/jdce_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the JPEG DCT coefficient effect block, bound to the top.
// Depends only on the top-level ports.
module jdce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Output item dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("Output data changed while stalled.");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output valid after reset.");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("Input not ready after reset.");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0)
        else $error("Output padding bits not zero.");

endmodule

bind jpeg_dct_coefficient_effect_core jdce_checker u_jdce_checker (.*);

>>> verif/jpeg_dct_coefficient_effect_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for jpeg_dct_coefficient_effect_core: streams coefficients under
// many register settings and checks every output item against an in-bench predictor.
// Depends on jdce_pkg and the core; bursty sender, stalling receiver, one long hold-off.
module jpeg_dct_coefficient_effect_core_test;
    import jdce_pkg::*;

    localparam int CLOCK_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 45;
    localparam int REPORT_LIMIT  = 60;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct {
        logic [COMP_W-1:0]        comp;
        logic [POS_W-1:0]         pos;
        logic signed [COEF_W-1:0] coef;
        logic                     last;
    } coef_item_t;

    typedef struct {
        logic signed [COEF_W-1:0] coef;
        logic                     status;
        logic                     last;
    } coef_result_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]     i_cfg_addr    = '0;
    logic [CFG_DW-1:0]     i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;  // position, coef_in
    logic [COMP_W-1:0]     s_axis_tuser  = '0;  // component
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;        // coef_out
    logic                  m_axis_tuser;        // status
    logic                  m_axis_tlast;

    jpeg_dct_coefficient_effect_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    logic [MODE_W-1:0]          sh_mode;
    logic                       sh_ycbcr;
    logic signed [OFFSET_W-1:0] sh_luma_off;
    logic signed [OFFSET_W-1:0] sh_cb_off;
    logic signed [OFFSET_W-1:0] sh_cr_off;
    logic [QUANT_W-1:0]         sh_qy;
    logic [QUANT_W-1:0]         sh_qcb;
    logic [QUANT_W-1:0]         sh_qcr;

    coef_item_t   coef_feed_q[$];
    coef_result_t coef_expect_q[$];
    coef_item_t   coef_on_bus;

    int feed_pushed   = 0;
    int feed_accepted = 0;
    int dc_accepted   = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int settings_run  = 0;
    int cycle_cnt     = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int tx_gap_max    = 0;
    int rx_mode       = 0;
    int rx_tick       = 0;
    int hold_left     = 0;
    logic hold_go     = 1'b0;
    logic hold_done   = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic signed [COEF_W-1:0] shifted_dc(logic signed [COEF_W-1:0] c,
                                                             logic [QUANT_W-1:0] q,
                                                             logic signed [OFFSET_W-1:0] off);
        longint qq;
        longint v;
        qq = (q == 0) ? 64'sd1 : longint'(q);
        v = longint'(c) * qq + longint'(off);
        if (v > DC_LIMIT)
            v = DC_LIMIT;
        else if (v < -DC_LIMIT)
            v = -DC_LIMIT;
        v = v / qq;
        return v[COEF_W-1:0];
    endfunction

    function automatic coef_result_t edit_coef(coef_item_t it);
        coef_result_t r;
        r.coef   = it.coef;
        r.status = 1'b0;
        r.last   = it.last;
        case (sh_mode)
            MODE_GRAY: begin
                if (it.comp != COMP_Y)
                    r.coef = '0;
            end
            MODE_PIXEL: begin
                if (it.pos != POS_DC)
                    r.coef = '0;
            end
            MODE_TINT: begin
                if (!sh_ycbcr) begin
                    r.status = 1'b1;
                end else if (it.pos == POS_DC) begin
                    if (it.comp == COMP_CB && sh_cb_off != 0)
                        r.coef = shifted_dc(it.coef, sh_qcb, sh_cb_off);
                    else if (it.comp == COMP_CR && sh_cr_off != 0)
                        r.coef = shifted_dc(it.coef, sh_qcr, sh_cr_off);
                end
            end
            MODE_LUMA: begin
                if (it.comp == COMP_Y && it.pos == POS_DC)
                    r.coef = shifted_dc(it.coef, sh_qy, sh_luma_off);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                coef_expect_q.push_back(edit_coef(coef_on_bus));
                feed_accepted++;
                if (coef_on_bus.pos == POS_DC)
                    dc_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (coef_feed_q.size() > 0) begin
                    coef_on_bus = coef_feed_q.pop_front();
                    s_axis_tdata  <= {{(S_DATA_W - COEF_W - POS_W){1'b0}},
                                      coef_on_bus.coef, coef_on_bus.pos};
                    s_axis_tuser  <= coef_on_bus.comp;
                    s_axis_tlast  <= coef_on_bus.last;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: per-phase stall pattern, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1;
            if (hold_go && !hold_done) begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (rx_tick % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (coef_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected item, expected none, got coef %0d", $time,
                             $signed(m_axis_tdata[COEF_W-1:0]));
            end else begin
                coef_result_t want;
                want = coef_expect_q.pop_front();
                if (m_axis_tdata[COEF_W-1:0] !== want.coef) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: coef_out expected %0d, actual %0d", $time,
                                 want.coef, $signed(m_axis_tdata[COEF_W-1:0]));
                end
                if (m_axis_tuser !== want.status) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: status expected %0d, actual %0d", $time,
                                 want.status, m_axis_tuser);
                end
                if (m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: last_out expected %0d, actual %0d", $time,
                                 want.last, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CLOCK_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_MODE:     sh_mode     = val[MODE_W-1:0];
            CFG_YCBCR:    sh_ycbcr    = val[0];
            CFG_LUMA_OFF: sh_luma_off = val[OFFSET_W-1:0];
            CFG_CB_OFF:   sh_cb_off   = val[OFFSET_W-1:0];
            CFG_CR_OFF:   sh_cr_off   = val[OFFSET_W-1:0];
            CFG_QUANT_Y:  sh_qy       = val;
            CFG_QUANT_CB: sh_qcb      = val;
            CFG_QUANT_CR: sh_qcr      = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic feed(logic [COMP_W-1:0] comp, logic [POS_W-1:0] pos,
                        logic signed [COEF_W-1:0] coef, logic last);
        coef_item_t it;
        it.comp = comp;
        it.pos  = pos;
        it.coef = coef;
        it.last = last;
        coef_feed_q.push_back(it);
        feed_pushed++;
    endtask

    task automatic wait_idle();
        while (feed_accepted != feed_pushed || coef_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        settings_run++;
    endtask

    function automatic logic [CFG_DW-1:0] pick_offset();
        logic signed [OFFSET_W-1:0] off;
        int r;
        r = $urandom_range(0, 19);
        if (r < 4)
            off = '0;
        else if (r < 6)
            off = -13'sd4096;
        else if (r < 8)
            off = 13'sd4095;
        else
            off = OFFSET_W'($urandom_range(0, 8191));
        return {{(CFG_DW - OFFSET_W){off[OFFSET_W-1]}}, off};
    endfunction

    function automatic logic [CFG_DW-1:0] pick_quant();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return CFG_DW'($urandom_range(1, 8));
        else if (r < 7)
            return CFG_DW'($urandom_range(9, 300));
        else if (r == 7)
            return '0;
        else if (r == 8)
            return 16'hFFFF;
        else
            return CFG_DW'($urandom_range(0, 65535));
    endfunction

    task automatic random_setting();
        int r;
        logic [MODE_W-1:0] mode;
        r = $urandom_range(0, 9);
        if (r < 3)
            mode = MODE_TINT;
        else if (r < 6)
            mode = MODE_LUMA;
        else if (r == 6)
            mode = MODE_GRAY;
        else if (r == 7)
            mode = MODE_PIXEL;
        else if (r == 8)
            mode = MODE_PASS;
        else
            mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        cfg_write(CFG_MODE, {{(CFG_DW - MODE_W){1'b0}}, mode});
        cfg_write(CFG_YCBCR, ($urandom_range(0, 6) != 0) ? 16'd1 : 16'd0);
        cfg_write(CFG_LUMA_OFF, pick_offset());
        cfg_write(CFG_CB_OFF, pick_offset());
        cfg_write(CFG_CR_OFF, pick_offset());
        cfg_write(CFG_QUANT_Y, pick_quant());
        cfg_write(CFG_QUANT_CB, pick_quant());
        cfg_write(CFG_QUANT_CR, pick_quant());
    endtask

    task automatic random_items(int count);
        logic [COMP_W-1:0] comp;
        logic [POS_W-1:0] pos;
        logic signed [COEF_W-1:0] coef;
        int r;
        for (int k = 0; k < count; k++) begin
            comp = ($urandom_range(0, 7) == 0) ? 2'd3 : COMP_W'($urandom_range(0, 2));
            pos  = ($urandom_range(0, 9) < 4) ? POS_DC : POS_W'($urandom_range(0, 63));
            r = $urandom_range(0, 19);
            case (r)
                0:       coef = -12'sd2048;
                1:       coef = 12'sd2047;
                2:       coef = '0;
                3:       coef = -12'sd1;
                default: coef = COEF_W'($urandom_range(0, 4095));
            endcase
            feed(comp, pos, coef, $urandom_range(0, 19) == 0);
        end
    endtask

    initial begin
        sh_mode     = MODE_PASS;
        sh_ycbcr    = 1'b1;
        sh_luma_off = '0;
        sh_cb_off   = '0;
        sh_cr_off   = '0;
        sh_qy       = 16'd1;
        sh_qcb      = 16'd1;
        sh_qcr      = 16'd1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Luminance with zero offset still clamps a large DC.
        cfg_write(CFG_MODE, CFG_DW'(MODE_LUMA));
        cfg_write(CFG_QUANT_Y, 16'd1);
        cfg_write(CFG_LUMA_OFF, 16'd0);
        feed(COMP_Y, POS_DC, 12'sd2047, 1'b0);
        feed(COMP_Y, POS_DC, -12'sd2048, 1'b0);
        feed(COMP_Y, 6'd63, -12'sd2048, 1'b0);
        feed(COMP_CB, POS_DC, 12'sd100, 1'b0);
        wait_idle();

        // Widest product and sum, then a quantizer of zero.
        cfg_write(CFG_LUMA_OFF, 16'h0FFF);
        cfg_write(CFG_QUANT_Y, 16'hFFFF);
        feed(COMP_Y, POS_DC, -12'sd2048, 1'b1);
        feed(COMP_Y, POS_DC, 12'sd1, 1'b0);
        wait_idle();
        cfg_write(CFG_QUANT_Y, 16'd0);
        cfg_write(CFG_LUMA_OFF, 16'hF000);
        feed(COMP_Y, POS_DC, 12'sd5, 1'b0);
        wait_idle();

        // Tint on both chroma components, on another component and on AC terms.
        cfg_write(CFG_MODE, CFG_DW'(MODE_TINT));
        cfg_write(CFG_YCBCR, 16'd1);
        cfg_write(CFG_CB_OFF, 16'hF000);
        cfg_write(CFG_CR_OFF, 16'h0FFF);
        cfg_write(CFG_QUANT_CB, 16'd3);
        cfg_write(CFG_QUANT_CR, 16'd7);
        feed(COMP_CB, POS_DC, 12'sd10, 1'b0);
        feed(COMP_CR, POS_DC, -12'sd300, 1'b0);
        feed(2'd3, POS_DC, 12'sd55, 1'b0);
        feed(COMP_CB, 6'd5, 12'sd9, 1'b0);
        feed(COMP_Y, POS_DC, 12'sd12, 1'b0);
        wait_idle();
        cfg_write(CFG_CB_OFF, 16'd0);
        feed(COMP_CB, POS_DC, -12'sd77, 1'b0);
        wait_idle();

        // Tint requested on an image that is not YCbCr.
        cfg_write(CFG_YCBCR, 16'd0);
        feed(COMP_CR, POS_DC, 12'sd40, 1'b1);
        feed(COMP_Y, 6'd17, -12'sd1, 1'b0);
        wait_idle();

        cfg_write(CFG_MODE, CFG_DW'(MODE_GRAY));
        cfg_write(CFG_YCBCR, 16'd1);
        feed(COMP_Y, 6'd9, -12'sd5, 1'b0);
        feed(COMP_CB, POS_DC, 12'sd3, 1'b0);
        feed(2'd3, 6'd63, -12'sd2048, 1'b0);
        wait_idle();

        cfg_write(CFG_MODE, CFG_DW'(MODE_PIXEL));
        feed(COMP_CR, POS_DC, 12'sd2047, 1'b0);
        feed(COMP_Y, 6'd1, 12'sd5, 1'b0);
        feed(2'd3, 6'd63, -12'sd1, 1'b1);
        wait_idle();

        cfg_write(CFG_MODE, CFG_DW'(MODE_PASS));
        feed(COMP_CB, POS_DC, -12'sd2048, 1'b0);
        wait_idle();
        cfg_write(CFG_MODE, CFG_DW'(MODE_SPARE_LO));
        feed(COMP_Y, POS_DC, 12'sd7, 1'b0);
        wait_idle();
        cfg_write(CFG_MODE, CFG_DW'(MODE_SPARE_HI));
        feed(COMP_CR, 6'd63, -12'sd3, 1'b1);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            rx_mode    <= p % 4;
            tx_gap_max <= (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 8);
            random_setting();
            if (p == 2)
                hold_go <= 1'b1;
            random_items(PHASE_ITEMS);
            wait_idle();
        end

        $display("Checked %0d output items (%0d DC terms) across %0d register settings.",
                 results_seen, dc_accepted, settings_run);
        if (mismatches == 0 && coef_expect_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/jdce_pkg.sv
rtl/jdce_front.sv
rtl/jdce_queue.sv
rtl/jdce_back.sv
rtl/jpeg_dct_coefficient_effect_core.sv
rtl/jdce_checker.sv
verif/jpeg_dct_coefficient_effect_core_test.sv
